[hdl/sukt_pkg.sv]
// Shared types and constants for the sorted unique key table.
`timescale 1ns / 1ps
package sukt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int FIELD_W  = 7;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [KEY_W-1:0]        word_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [FIELD_W-1:0]      field_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_SHIFT_DN,
        ST_FINISH
    } state_t;

endpackage

[hdl/sukt_cmd_if.sv]
// Command channel: selector and key with valid/ready handshake.
`timescale 1ns / 1ps
interface sukt_cmd_if;
    import sukt_pkg::*;

    logic valid;
    logic ready;
    cmd_t cmd;
    key_t key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

[hdl/sukt_res_if.sv]
// Result channel: status, positions and entry count with valid/ready handshake.
`timescale 1ns / 1ps
interface sukt_res_if;
    import sukt_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    field_t  pos_front;
    field_t  pos_back;
    field_t  entry_count;

    modport source (output valid, output status, output pos_front, output pos_back,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input pos_front, input pos_back,
                    input entry_count, output ready);
endinterface

[hdl/sukt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sukt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/sorted_unique_key_table_unit.sv]
// Sorted unique key table: ordered key array in one RAM, scanned and shifted per word.
// Steps: scan reads keys up to the first one not below the given key or the last held key;
//   exec decides; an insert shifts the tail up a word at a time, then place writes the key,
//   a delete shifts it down; finish loads the result. An empty table skips scan, a clear
//   goes straight to finish. A new command is taken only once the last result is loaded.
// Reset: asynchronous, active low; empties the table at once, RAM contents left as they are.
`timescale 1ns / 1ps
module sorted_unique_key_table_unit (
    input  logic       clk,
    input  logic       rst_n,
    sukt_cmd_if.sink   req,
    sukt_res_if.source rsp
);
    import sukt_pkg::*;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    logic    out_valid_reg, out_valid_next;

    cmd_t    cmd_reg, cmd_next;
    key_t    key_reg, key_next;
    cnt_t    idx_reg, idx_next;
    logic    hit_reg, hit_next;
    addr_t   sh_reg, sh_next;
    status_t status_reg, status_next;
    field_t  front_reg, front_next;
    field_t  back_reg, back_next;
    status_t out_status_reg, out_status_next;
    field_t  out_front_reg, out_front_next;
    field_t  out_back_reg, out_back_next;
    field_t  out_count_reg, out_count_next;

    logic    wr_en;
    addr_t   wr_addr;
    word_t   wr_data;
    addr_t   rd_addr;
    word_t   rd_data;

    key_t    rd_key;
    logic    key_ge;
    logic    key_eq;
    cnt_t    idx_inc;
    cnt_t    cnt_dec;
    logic    out_load;

    sukt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key   = key_t'(rd_data);
    assign key_ge   = (rd_key >= key_reg);
    assign key_eq   = (rd_key == key_reg);
    assign idx_inc  = cnt_t'(idx_reg + 1'b1);
    assign cnt_dec  = cnt_t'(count_reg - 1'b1);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.pos_front   = out_front_reg;
    assign rsp.pos_back    = out_back_reg;
    assign rsp.entry_count = out_count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == CMD_CLEAR)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (key_ge || (idx_inc == count_reg))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (!hit_reg && (count_reg != cnt_t'(CAPACITY))
                            && (idx_reg != count_reg))
                        begin
                            state_next = ST_SHIFT_UP;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (hit_reg && (idx_reg != cnt_dec))
                        begin
                            state_next = ST_SHIFT_DN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SHIFT_UP:
            begin
                if (sh_reg == idx_reg[ADDR_W-1:0])
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_FINISH;
            end
            ST_SHIFT_DN:
            begin
                if (sh_reg == cnt_dec[ADDR_W-1:0])
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        sh_next         = sh_reg;
        status_next     = status_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        out_status_next = out_status_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        wr_en           = 1'b0;
        wr_addr         = addr_t'(sh_reg + 1'b1);
        wr_data         = rd_data;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    status_next = STAT_DONE;
                    front_next  = '0;
                    back_next   = '0;
                    if (req.cmd == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // Data on rd_data belongs to entry idx_reg; stop at the first key not below.
                if (key_ge)
                begin
                    hit_next = key_eq;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[ADDR_W-1:0];
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = STAT_MISS;
                        end
                        else if (count_reg == cnt_t'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (idx_reg == count_reg)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = idx_reg[ADDR_W-1:0];
                            wr_data    = word_t'(key_reg);
                            count_next = cnt_t'(count_reg + 1'b1);
                        end
                        else
                        begin
                            // Move the tail up, starting from the last held key.
                            rd_addr = cnt_dec[ADDR_W-1:0];
                            sh_next = cnt_dec[ADDR_W-1:0];
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = STAT_MISS;
                        end
                        else if (idx_reg == cnt_dec)
                        begin
                            count_next = cnt_dec;
                        end
                        else
                        begin
                            // Move the tail down, starting just past the removed key.
                            rd_addr = idx_inc[ADDR_W-1:0];
                            sh_next = idx_inc[ADDR_W-1:0];
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (hit_reg)
                        begin
                            front_next = FIELD_W'(idx_inc);
                            back_next  = FIELD_W'(cnt_t'(count_reg - idx_reg));
                        end
                        else
                        begin
                            status_next = STAT_MISS;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_DONE;
                    end
                endcase
            end
            ST_SHIFT_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_t'(sh_reg + 1'b1);
                wr_data = rd_data;
                sh_next = addr_t'(sh_reg - 1'b1);
                rd_addr = addr_t'(sh_reg - 1'b1);
            end
            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[ADDR_W-1:0];
                wr_data    = word_t'(key_reg);
                count_next = cnt_t'(count_reg + 1'b1);
            end
            ST_SHIFT_DN:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_t'(sh_reg - 1'b1);
                wr_data = rd_data;
                if (sh_reg == cnt_dec[ADDR_W-1:0])
                begin
                    count_next = cnt_dec;
                end
                else
                begin
                    sh_next = addr_t'(sh_reg + 1'b1);
                    rd_addr = addr_t'(sh_reg + 1'b1);
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_front_next  = front_reg;
                    out_back_next   = back_reg;
                    out_count_next  = FIELD_W'(count_reg);
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        sh_reg         <= sh_next;
        status_reg     <= status_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        out_status_reg <= out_status_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_count_reg  <= out_count_next;
    end

endmodule

[test/sorted_unique_key_table_unit_tb.sv]
// Testbench for the sorted unique key table: random and directed commands, checked by a scoreboard.
`timescale 1ns / 1ps
module sorted_unique_key_table_unit_tb;
    import sukt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
    localparam int PHASE_WORDS    = 500;
    localparam int MIX_SPAN       = 96;

    typedef struct packed {
        status_t status;
        field_t  pos_front;
        field_t  pos_back;
        field_t  entry_count;
    } table_result_t;

    typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_t;

    class key_table_scoreboard;
        key_t          held_keys[$];
        table_result_t pending[$];
        int            errors;
        int            n_cmd [4];
        int            n_full;
        int            n_dup;
        int            n_hit;
        int            peak;

        // Apply one accepted command to the shadow table and queue the result it must give.
        function void note_command(cmd_t c, key_t k);
            int            idx;
            bit            hit;
            table_result_t r;
            idx = 0;
            while (idx < held_keys.size() && held_keys[idx] < k)
                idx++;
            hit = (idx < held_keys.size()) && (held_keys[idx] == k);
            r = '{status: STAT_DONE, pos_front: '0, pos_back: '0, entry_count: '0};
            n_cmd[c]++;
            case (c)
                CMD_INSERT: begin
                    if (hit) begin
                        r.status = STAT_MISS;
                        n_dup++;
                    end else if (held_keys.size() >= CAPACITY) begin
                        r.status = STAT_FULL;
                        n_full++;
                    end else begin
                        held_keys.insert(idx, k);
                    end
                end
                CMD_DELETE: begin
                    if (hit)
                        held_keys.delete(idx);
                    else
                        r.status = STAT_MISS;
                end
                CMD_SEARCH: begin
                    if (hit) begin
                        r.pos_front = field_t'(idx + 1);
                        r.pos_back  = field_t'(held_keys.size() - idx);
                        n_hit++;
                    end else begin
                        r.status = STAT_MISS;
                    end
                end
                default: held_keys.delete();
            endcase
            r.entry_count = field_t'(held_keys.size());
            if (held_keys.size() > peak)
                peak = held_keys.size();
            pending.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (pending.size() == 0) begin
                $error("result word with no command outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.pos_front !== want.pos_front) begin
                $error("pos_front: expected %0d, got %0d", want.pos_front, got.pos_front);
                errors++;
            end
            if (got.pos_back !== want.pos_back) begin
                $error("pos_back: expected %0d, got %0d", want.pos_back, got.pos_back);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    key_table_scoreboard sb = new();

    sukt_cmd_if cmd_ch ();
    sukt_res_if res_ch ();

    sorted_unique_key_table_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: check each accepted word, then stall at random.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_result('{status: res_ch.status, pos_front: res_ch.pos_front,
                                  pos_back: res_ch.pos_back, entry_count: res_ch.entry_count});
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("sorted_unique_key_table_unit_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_command(input cmd_t c, input key_t k);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd   <= c;
        cmd_ch.key   <= k;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(c, k);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain;
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    function automatic key_t pick_key();
        int r;
        int n;
        r = $urandom_range(99);
        n = sb.held_keys.size();
        if (r < 35 && n > 0)
            return sb.held_keys[$urandom_range(n - 1)];
        if (r < 50 && n > 0)
            return key_t'(sb.held_keys[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1));
        if (r < 60) begin
            case ($urandom_range(3))
                0: return key_t'(32'h8000_0000);
                1: return key_t'(32'h7FFF_FFFF);
                2: return key_t'(0);
                default: return key_t'(-1);
            endcase
        end
        if (r < 75)
            return key_t'(int'($urandom_range(31)) - 16);
        return key_t'($urandom);
    endfunction

    function automatic cmd_t pick_cmd(mix_t mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW:
                return (r < 80) ? CMD_INSERT : (r < 95) ? CMD_SEARCH : CMD_DELETE;
            MIX_SHRINK:
                return (r < 55) ? CMD_DELETE : (r < 80) ? CMD_SEARCH :
                       (r < 95) ? CMD_INSERT : CMD_CLEAR;
            default:
                return (r < 40) ? CMD_INSERT : (r < 65) ? CMD_SEARCH :
                       (r < 97) ? CMD_DELETE : CMD_CLEAR;
        endcase
    endfunction

    task automatic run_directed;
        send_command(CMD_SEARCH, key_t'(0));
        send_command(CMD_DELETE, key_t'(5));
        send_command(CMD_INSERT, key_t'(32'h8000_0000));
        send_command(CMD_INSERT, key_t'(32'h7FFF_FFFF));
        send_command(CMD_INSERT, key_t'(0));
        send_command(CMD_INSERT, key_t'(-1));
        send_command(CMD_INSERT, key_t'(1));
        send_command(CMD_INSERT, key_t'(32'h8000_0000));
        send_command(CMD_SEARCH, key_t'(32'h8000_0000));
        send_command(CMD_SEARCH, key_t'(32'h7FFF_FFFF));
        send_command(CMD_SEARCH, key_t'(0));
        send_command(CMD_SEARCH, key_t'(12345));
        send_command(CMD_DELETE, key_t'(0));
        send_command(CMD_DELETE, key_t'(32'h8000_0000));
        send_command(CMD_DELETE, key_t'(32'h7FFF_FFFF));
        send_command(CMD_SEARCH, key_t'(1));
        send_command(CMD_CLEAR,  key_t'(32'hFFFF_FFFF));
        send_command(CMD_SEARCH, key_t'(-1));
        send_command(CMD_INSERT, key_t'(32'h5555_5555));
        send_command(CMD_INSERT, key_t'(32'hAAAA_AAAA));
        send_command(CMD_SEARCH, key_t'(32'hAAAA_AAAA));
        send_command(CMD_CLEAR,  key_t'(0));
        send_command(CMD_CLEAR,  key_t'(0));
    endtask

    // Cycle through grow, balanced and shrink mixes so the table fills up and empties repeatedly.
    task automatic run_random(input int words, input int offset);
        mix_t mix;
        for (int i = 0; i < words; i++)
        begin
            case (((i / MIX_SPAN) + offset) % 4)
                0: mix = MIX_GROW;
                2: mix = MIX_SHRINK;
                default: mix = MIX_BALANCED;
            endcase
            if (i == words / 2)
                drain();
            send_command(pick_cmd(mix), pick_key());
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.cmd    <= CMD_INSERT;
        cmd_ch.key    <= '0;
        send_idle_pct = 18;
        recv_idle_pct = 46;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(PHASE_WORDS, 0);
        drain();
        send_idle_pct = 46;
        recv_idle_pct = 18;
        run_random(PHASE_WORDS, 1);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_WORDS, 3);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("covered %0d inserts, %0d deletes, %0d searches, %0d clears",
                 sb.n_cmd[CMD_INSERT], sb.n_cmd[CMD_DELETE],
                 sb.n_cmd[CMD_SEARCH], sb.n_cmd[CMD_CLEAR]);
        $display("%0d full-table rejects, %0d duplicates, %0d search hits, peak fill %0d",
                 sb.n_full, sb.n_dup, sb.n_hit, sb.peak);
        if (sb.errors == 0)
            $display("sorted_unique_key_table_unit_tb OK");
        else
            $display("sorted_unique_key_table_unit_tb NOT OK");
        $finish;
    end

endmodule

[sorted_unique_key_table_unit.f]
hdl/sukt_pkg.sv
hdl/sukt_cmd_if.sv
hdl/sukt_res_if.sv
hdl/sukt_ram.sv
hdl/sorted_unique_key_table_unit.sv
test/sorted_unique_key_table_unit_tb.sv
